### src/lkvc_pkg.sv
// types and constants shared by the lru key-value cache
package lkvc_pkg;

   localparam int unsigned ENTRIES_DEF = 16;
   localparam int unsigned CAP_W       = 5;
   localparam int unsigned KEY_W       = 32;
   localparam int unsigned DATA_W      = 32;

   localparam logic [CAP_W-1:0]         CAP_RESET = 5'd16;
   localparam logic signed [DATA_W-1:0] MISS_DATA = -32'sd1;

   typedef enum logic {
      CMD_GET = 1'b0,
      CMD_SET = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SCAN   = 2'd1,
      ST_UPDATE = 2'd2
   } state_type;

   typedef struct packed {
      cmd_type                   cmd;
      logic signed [KEY_W-1:0]   key;
      logic signed [DATA_W-1:0]  data_in;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic signed [DATA_W-1:0]  data_out;
   } rsp_type;

endpackage

### src/lru_key_value_cache_top.sv
// lru key-value cache: fully associative store with least recently used replacement
//
// req channel (valid/ready) carries one beat per command: cmd get looks a key up,
// cmd set inserts or overwrites a key. every get yields one rsp beat (hit flag and
// value, all ones on a miss); a set yields none.
// csr_we writes the capacity register (1..ENTRIES, 0 acts as 1, larger saturates);
// write it only while the block is idle.
// keys and values live in one synchronous ram scanned one entry a cycle; valid
// bits and recency ranks sit in flops and are all updated in a single cycle.
// an item goes through the accept state, the ram scan (one read a cycle, read
// data registered) and the update state before the next req_ready. a get result
// is in rsp_data on the cycle after the update.
// req_ready is high only while idle. the rsp output register may hold a result
// while the next command is accepted and scanned; a get whose result cannot be
// placed waits in the update cycle until rsp_ready frees the register.
// reset empties the store and sets capacity to 16; the ram is not cleared.
module lru_key_value_cache_top #(
   parameter int unsigned ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  lkvc_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output lkvc_pkg::rsp_type            rsp_data,
   input  logic                         csr_we,
   input  logic [lkvc_pkg::CAP_W-1:0]   csr_wdata
);
   import lkvc_pkg::*;

   localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned LW = $clog2(ENTRIES + 1);
   localparam int unsigned SW = (LW > CAP_W) ? LW : CAP_W;
   localparam int unsigned MW = KEY_W + DATA_W;

   state_type            state_ff, state_in;
   logic [LW-1:0]        cnt_ff, cnt_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic [IW-1:0]        chk_idx_ff, chk_idx_in;
   req_type              req_ff, req_in;
   logic                 found_ff, found_in;
   logic [IW-1:0]        match_idx_ff, match_idx_in;
   logic [IW-1:0]        match_age_ff, match_age_in;
   logic [DATA_W-1:0]    match_val_ff, match_val_in;
   logic                 free_found_ff, free_found_in;
   logic [IW-1:0]        free_idx_ff, free_idx_in;
   logic [ENTRIES-1:0]   valid_ff, valid_in;
   logic [IW-1:0]        age_ff [ENTRIES];
   logic [IW-1:0]        age_in [ENTRIES];
   logic [LW-1:0]        live_ff, live_in;
   logic [CAP_W-1:0]     cap_ff, cap_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [MW-1:0]        kv_mem [ENTRIES];
   logic [MW-1:0]        mem_rdata_ff;
   logic                 mem_we;
   logic [IW-1:0]        mem_waddr;
   logic [MW-1:0]        mem_wdata;
   logic [IW-1:0]        mem_raddr;

   logic [SW-1:0]        cap_wide;
   logic [LW-1:0]        eff_cap;
   logic [LW-1:0]        thr;
   logic                 evict_en;
   logic                 update_go;
   logic [IW-1:0]        chk_age;
   logic [KEY_W-1:0]     rd_key;

   // key/value ram
   always_ff @(posedge clock) begin
      if (mem_we) begin
         kv_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= kv_mem[mem_raddr];
   end

   assign mem_raddr = cnt_ff[IW-1:0];
   assign rd_key    = mem_rdata_ff[MW-1 -: KEY_W];
   assign chk_age   = age_ff[chk_idx_ff];

   // capacity clamped to 1..ENTRIES
   always_comb begin
      cap_wide = SW'(cap_ff);
      if (cap_wide == '0) begin
         eff_cap = LW'(1);
      end else if (cap_wide > SW'(ENTRIES)) begin
         eff_cap = LW'(ENTRIES);
      end else begin
         eff_cap = LW'(cap_wide);
      end
      thr      = eff_cap - LW'(1);
      evict_en = (req_ff.cmd == CMD_SET) && (live_ff >= eff_cap);
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = cnt_ff[IW-1:0];
      req_in        = req_ff;
      found_in      = found_ff;
      match_idx_in  = match_idx_ff;
      match_age_in  = match_age_ff;
      match_val_in  = match_val_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      valid_in      = valid_ff;
      age_in        = age_ff;
      live_in       = live_ff;
      cap_in        = csr_we ? csr_wdata : cap_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = match_idx_ff;
      mem_wdata     = {req_ff.key, req_ff.data_in};
      update_go     = 1'b0;
      req_ready     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in        = req_data;
               cnt_in        = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff < LW'(ENTRIES)) begin
               chk_valid_in = 1'b1;
               cnt_in       = cnt_ff + LW'(1);
            end else begin
               state_in = ST_UPDATE;
            end
            if (chk_valid_ff) begin
               if (!found_ff && valid_ff[chk_idx_ff] && (rd_key == req_ff.key)) begin
                  found_in     = 1'b1;
                  match_idx_in = chk_idx_ff;
                  match_age_in = chk_age;
                  match_val_in = mem_rdata_ff[DATA_W-1:0];
               end
               // first slot that is empty or about to be evicted
               if (!free_found_ff && (!valid_ff[chk_idx_ff] ||
                                      (evict_en && (LW'(chk_age) >= thr)))) begin
                  free_found_in = 1'b1;
                  free_idx_in   = chk_idx_ff;
               end
            end
         end
         ST_UPDATE: begin
            update_go = (req_ff.cmd == CMD_SET) || !rsp_valid_ff || rsp_ready;
            if (update_go) begin
               state_in = ST_IDLE;
               if (found_ff) begin
                  // make the matching entry most recent
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (valid_ff[i] && (age_ff[i] < match_age_ff)) begin
                        age_in[i] = age_ff[i] + IW'(1);
                     end
                  end
                  age_in[match_idx_ff] = '0;
                  if (req_ff.cmd == CMD_SET) begin
                     mem_we = 1'b1;
                  end
               end else if (req_ff.cmd == CMD_SET) begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (valid_ff[i]) begin
                        if (evict_en && (LW'(age_ff[i]) >= thr)) begin
                           valid_in[i] = 1'b0;
                           age_in[i]   = '0;
                        end else begin
                           age_in[i] = age_ff[i] + IW'(1);
                        end
                     end
                  end
                  valid_in[free_idx_ff] = 1'b1;
                  age_in[free_idx_ff]   = '0;
                  live_in               = (evict_en ? thr : live_ff) + LW'(1);
                  mem_we                = 1'b1;
                  mem_waddr             = free_idx_ff;
               end
               if (req_ff.cmd == CMD_GET) begin
                  rsp_valid_in    = 1'b1;
                  rsp_in.hit      = found_ff;
                  rsp_in.data_out = found_ff ? match_val_ff : MISS_DATA;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         chk_valid_ff  <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         valid_ff      <= '0;
         live_ff       <= '0;
         cap_ff        <= CAP_RESET;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            age_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         chk_valid_ff  <= chk_valid_in;
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         valid_ff      <= valid_in;
         live_ff       <= live_in;
         cap_ff        <= cap_in;
         rsp_valid_ff  <= rsp_valid_in;
         age_ff        <= age_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      chk_idx_ff   <= chk_idx_in;
      req_ff       <= req_in;
      match_idx_ff <= match_idx_in;
      match_age_ff <= match_age_in;
      match_val_ff <= match_val_in;
      free_idx_ff  <= free_idx_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_live_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(live_ff))
      else $error("live count differs from number of valid entries");

   a_free_slot_on_insert: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && req_ff.cmd == CMD_SET && !found_ff) |-> free_found_ff)
      else $error("insert without a free slot");

   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("response raised outside update");

   a_get_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (update_go && req_ff.cmd == CMD_GET) |=> rsp_valid_ff)
      else $error("get finished without a response beat");

   a_live_in_range: assert property (@(posedge clock) disable iff (reset)
      int'(live_ff) <= ENTRIES)
      else $error("live count above entries");

endmodule
